// ===== sv/mtpp_pkg.sv =====
// Shared types and constants of the majority-trend page prefetcher.
// Used by the front, queue, back and top-level modules; depends on nothing.
package mtpp_pkg;

    // Field widths
    localparam int PAGE_W   = 52;
    localparam int DELTA_W  = 53;
    localparam int TDATA_W  = 56;
    localparam int REMAIN_W = 3;

    // Readahead lengths in pages
    localparam int RA_SHORT = 4;
    localparam int RA_LONG  = 8;

    // Smallest vote region and hit counter ceiling
    localparam int VOTE_START = 2;
    localparam logic [1:0] HIT_SAT = 2'd3;

    // Opcodes carried on the input tuser
    localparam logic OP_HIT   = 1'b0;
    localparam logic OP_FAULT = 1'b1;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // One classified access, passed from the front to the back
    typedef struct packed {
        logic                  fault;
        logic [PAGE_W-1:0]     page;
        logic [DELTA_W-1:0]    delta;
        logic                  ra_long;
        logic                  up;
    } qentry_t;

endpackage

// ===== sv/mtpp_front.sv =====
// Front end of the prefetcher: accepts accesses, computes the delta to the last page,
// tracks hits since the last fault and the direction for linear readahead.
// Depends on mtpp_pkg.
module mtpp_front
    import mtpp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_opcode,
    input  logic [PAGE_W-1:0]   in_page,
    output logic                q_valid,
    input  logic                q_ready,
    output qentry_t             q_data
);

    logic              primed_reg, primed_next;
    logic [PAGE_W-1:0] last_page_reg, last_page_next;
    logic [PAGE_W-1:0] prev_fault_reg, prev_fault_next;
    logic [1:0]        hits_reg, hits_next;
    logic              accept;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign accept   = in_valid & q_ready;

    // Classify the incoming item and build the queue entry.
    always_comb
    begin
        q_data.fault   = (in_opcode == OP_FAULT);
        q_data.page    = in_page;
        q_data.delta   = primed_reg ? ({1'b0, in_page} - {1'b0, last_page_reg})
                                    : '0;
        q_data.ra_long = (hits_reg == HIT_SAT);
        q_data.up      = (in_page > prev_fault_reg);
    end

    // Update the access history summary on every accepted item.
    always_comb
    begin
        primed_next     = primed_reg;
        last_page_next  = last_page_reg;
        prev_fault_next = prev_fault_reg;
        hits_next       = hits_reg;
        if (accept)
        begin
            primed_next    = 1'b1;
            last_page_next = in_page;
            if (in_opcode == OP_FAULT)
            begin
                hits_next       = 2'd0;
                prev_fault_next = in_page;
            end
            else if (hits_reg != HIT_SAT)
            begin
                hits_next = hits_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg     <= 1'b0;
            last_page_reg  <= '0;
            prev_fault_reg <= '0;
            hits_reg       <= 2'd0;
        end
        else
        begin
            primed_reg     <= primed_next;
            last_page_reg  <= last_page_next;
            prev_fault_reg <= prev_fault_next;
            hits_reg       <= hits_next;
        end
    end

endmodule

// ===== sv/mtpp_queue.sv =====
// Two-entry queue that decouples the front end from the back end.
// Depends on mtpp_pkg for the entry type.
module mtpp_queue
    import mtpp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  qentry_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output qentry_t pop_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    qentry_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ((wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1)
                              : wr_ptr_reg;
        rd_ptr_next = do_pop ? ((rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1)
                             : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/mtpp_back.sv =====
// Back end of the prefetcher: keeps the delta history ring, runs the majority vote
// on faults and emits the prefetch pages through an output register.
// Depends on mtpp_pkg.
module mtpp_back
    import mtpp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  qentry_t            q_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PAGE_W-1:0]  out_page,
    output logic               out_trend,
    output logic               out_last
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_VOTE,
        S_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [SW-1:0]        span_reg, span_next;
    logic [SW-1:0]        seq_reg, seq_next;
    logic                 pv_reg, pv_next;
    logic                 pfirst_reg, pfirst_next;
    logic                 ppass_reg, ppass_next;
    logic                 pfinal_reg, pfinal_next;
    logic [DELTA_W-1:0]   cand_reg, cand_next;
    logic [CW-1:0]        votes_reg, votes_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic                 ra_long_reg, ra_long_next;
    logic                 up_reg, up_next;
    logic [PAGE_W-1:0]    p_reg, p_next;
    logic [PAGE_W-1:0]    inc_reg, inc_next;
    logic [REMAIN_W-1:0]  remain_reg, remain_next;
    logic                 trend_reg, trend_next;
    logic                 m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0]    m_page_reg, m_page_next;
    logic                 m_trend_reg, m_trend_next;
    logic                 m_last_reg, m_last_next;

    // History memory
    logic [DELTA_W-1:0]   delta_mem [HISTORY_DEPTH];
    logic [DELTA_W-1:0]   rd_data_reg;
    logic                 wr_en, rd_en;
    logic [AW-1:0]        rd_addr;

    // Vote and emission helpers
    logic [SW-1:0]        span_x2;
    logic [SW-1:0]        age_wide;
    logic [AW:0]          slot_sum;
    logic                 match;
    logic [CW-1:0]        count_total;
    logic                 start_emit, start_trend, start_long, start_up;
    logic [DELTA_W-1:0]   start_step;
    logic [PAGE_W-1:0]    start_page;

    assign out_valid = m_valid_reg;
    assign out_page  = m_page_reg;
    assign out_trend = m_trend_reg;
    assign out_last  = m_last_reg;
    assign q_ready   = (state_reg == S_IDLE);

    assign span_x2   = span_reg << 1;
    assign rd_en     = (state_reg == S_VOTE) && (seq_reg < span_x2);
    assign age_wide  = (seq_reg < span_reg) ? seq_reg : (seq_reg - span_reg);
    assign wr_en     = q_valid && (state_reg == S_IDLE);

    // Ring slot of the entry a given age back from the newest one.
    always_comb
    begin
        slot_sum = {1'b0, head_reg} + (AW + 1)'(HISTORY_DEPTH - 1)
                   - {1'b0, age_wide[AW-1:0]};
        if (slot_sum >= (AW + 1)'(HISTORY_DEPTH))
        begin
            slot_sum = slot_sum - (AW + 1)'(HISTORY_DEPTH);
        end
        rd_addr = slot_sum[AW-1:0];
    end

    assign match       = (rd_data_reg == cand_reg);
    assign count_total = count_reg + CW'(match);

    // Main sequencer: push, vote, emit.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        span_next    = span_reg;
        seq_next     = seq_reg;
        pv_next      = rd_en;
        pfirst_next  = (age_wide == '0);
        ppass_next   = (seq_reg >= span_reg);
        pfinal_next  = (seq_reg == span_x2 - 1'b1);
        cand_next    = cand_reg;
        votes_next   = votes_reg;
        count_next   = count_reg;
        page_next    = page_reg;
        ra_long_next = ra_long_reg;
        up_next      = up_reg;
        p_next       = p_reg;
        inc_next     = inc_reg;
        remain_next  = remain_reg;
        trend_next   = trend_reg;
        m_valid_next = m_valid_reg & ~out_ready;
        m_page_next  = m_page_reg;
        m_trend_next = m_trend_reg;
        m_last_next  = m_last_reg;
        start_emit   = 1'b0;
        start_trend  = 1'b0;
        start_step   = cand_reg;
        start_page   = page_reg;
        start_long   = ra_long_reg;
        start_up     = up_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    // Push the delta into the ring.
                    head_next = (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    if (fill_reg != CW'(HISTORY_DEPTH))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (q_data.fault)
                    begin
                        page_next    = q_data.page;
                        ra_long_next = q_data.ra_long;
                        up_next      = q_data.up;
                        span_next    = SW'(VOTE_START);
                        seq_next     = '0;
                        if (fill_next >= CW'(VOTE_START))
                        begin
                            state_next = S_VOTE;
                        end
                        else
                        begin
                            start_emit = 1'b1;
                            start_page = q_data.page;
                            start_long = q_data.ra_long;
                            start_up   = q_data.up;
                        end
                    end
                end
            end

            S_VOTE:
            begin
                if (rd_en)
                begin
                    seq_next = seq_reg + 1'b1;
                end
                // Data read in the previous cycle is processed here.
                if (pv_reg)
                begin
                    if (!ppass_reg)
                    begin
                        // Boyer-Moore candidate pass.
                        if (pfirst_reg)
                        begin
                            cand_next  = rd_data_reg;
                            votes_next = CW'(1);
                        end
                        else if (match)
                        begin
                            votes_next = votes_reg + 1'b1;
                        end
                        else if (votes_reg == CW'(1))
                        begin
                            cand_next = rd_data_reg;
                        end
                        else
                        begin
                            votes_next = votes_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        // Counting pass for the candidate.
                        count_next = pfirst_reg ? CW'(match) : count_total;
                        if (pfinal_reg)
                        begin
                            if (SW'(count_total) > (span_reg >> 1))
                            begin
                                start_emit  = 1'b1;
                                start_trend = 1'b1;
                            end
                            else if (span_x2 <= SW'(fill_reg))
                            begin
                                span_next = span_x2;
                                seq_next  = '0;
                            end
                            else
                            begin
                                start_emit = 1'b1;
                            end
                        end
                    end
                end
            end

            S_EMIT:
            begin
                if (!m_valid_reg || out_ready)
                begin
                    m_valid_next = 1'b1;
                    m_page_next  = p_reg;
                    m_trend_next = trend_reg;
                    m_last_next  = (remain_reg == REMAIN_W'(1));
                    p_next       = p_reg + inc_reg;
                    remain_next  = remain_reg - 1'b1;
                    if (remain_reg == REMAIN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Set up the run of prefetch pages once the vote is settled.
        if (start_emit)
        begin
            state_next = S_EMIT;
            trend_next = start_trend;
            if (start_trend)
            begin
                p_next      = start_page + PAGE_W'(1);
                inc_next    = start_step[PAGE_W-1:0];
                remain_next = start_long ? REMAIN_W'(RA_LONG - 1) : REMAIN_W'(RA_SHORT - 1);
            end
            else
            begin
                p_next      = start_up ? start_page + PAGE_W'(1) : start_page - PAGE_W'(1);
                inc_next    = start_up ? PAGE_W'(1) : '1;
                remain_next = start_long ? REMAIN_W'(RA_LONG - 2) : REMAIN_W'(RA_SHORT - 2);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            span_reg    <= SW'(VOTE_START);
            seq_reg     <= '0;
            pv_reg      <= 1'b0;
            pfirst_reg  <= 1'b0;
            ppass_reg   <= 1'b0;
            pfinal_reg  <= 1'b0;
            votes_reg   <= '0;
            count_reg   <= '0;
            remain_reg  <= '0;
            trend_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            span_reg    <= span_next;
            seq_reg     <= seq_next;
            pv_reg      <= pv_next;
            pfirst_reg  <= pfirst_next;
            ppass_reg   <= ppass_next;
            pfinal_reg  <= pfinal_next;
            votes_reg   <= votes_next;
            count_reg   <= count_next;
            remain_reg  <= remain_next;
            trend_reg   <= trend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        cand_reg    <= cand_next;
        page_reg    <= page_next;
        ra_long_reg <= ra_long_next;
        up_reg      <= up_next;
        p_reg       <= p_next;
        inc_reg     <= inc_next;
        m_page_reg  <= m_page_next;
        m_trend_reg <= m_trend_next;
        m_last_reg  <= m_last_next;
    end

    // History ring: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            delta_mem[head_reg] <= q_data.delta;
        end
        if (rd_en)
        begin
            rd_data_reg <= delta_mem[rd_addr];
        end
    end

    // The ring never reports more entries than it holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(HISTORY_DEPTH))
        else $error("history fill exceeds ring depth");

    // A vote region never reaches past the filled part of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VOTE) |-> (span_reg <= SW'(fill_reg)))
        else $error("vote region larger than history");

    // Emission always has at least one page left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (remain_reg != '0))
        else $error("emission with empty page count");

    // The queue is only drained while no fault is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !wr_en)
        else $error("history written during a fault");

endmodule

// ===== sv/majority_trend_page_prefetcher.sv =====
// Top level of the majority-trend page prefetcher.
// Instantiates mtpp_front, mtpp_queue and mtpp_back; depends on mtpp_pkg.
//
// Usage:
//   Input channel s_axis_*: one page access per item. tuser is the opcode
//   (0 = recorded hit, 1 = fault); tdata carries the page number.
//   Output channel m_axis_*: one prefetch page per item. tuser says whether
//   the majority delta trend was used, tlast marks the final page of a fault.
//   A hit produces no output; a fault produces 2, 3, 6 or 7 items.
//   Hits drain at one item per cycle while the back end is idle. A fault first
//   pushes its delta into the history, then the vote unit reads the delta ring
//   one entry per cycle, each region once for the candidate and once for the
//   count; regions of 2, 4, 8 and larger doubled sizes are tried in turn until
//   one has a majority or the next would not fit the filled history. Pages then
//   leave at one per cycle into the output register while the receiver is ready.
//   A two-entry queue lets the front accept items while the back votes or emits.
//   Reset empties the history, clears the hit count and the previous fault
//   page. When the receiver stalls, the output register holds its item and
//   the back end waits; the input keeps accepting until the queue fills.
module majority_trend_page_prefetcher
    import mtpp_pkg::*;
#(
    parameter int HISTORY_DEPTH = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // [51:0] page_number, [55:52] zero
    input  logic               s_axis_tuser,   // [0] opcode
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // [51:0] prefetch_page, [55:52] zero
    output logic               m_axis_tuser,   // [0] by_trend
    output logic               m_axis_tlast
);

    logic              fq_valid, fq_ready;
    qentry_t           fq_data;
    logic              qb_valid, qb_ready;
    qentry_t           qb_data;
    logic [PAGE_W-1:0] out_page;

    mtpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser),
        .in_page   (s_axis_tdata[PAGE_W-1:0]),
        .q_valid   (fq_valid),
        .q_ready   (fq_ready),
        .q_data    (fq_data)
    );

    mtpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    mtpp_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_page  (out_page),
        .out_trend (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(TDATA_W - PAGE_W){1'b0}}, out_page};

endmodule
